@@ design/acsi_pkg.sv @@
// ----------------------------------------------------------------------------
// ANSI CSI console parser package
// Command codes, byte codes of the escape syntax, and the SGR color mapping.
// ----------------------------------------------------------------------------
package acsi_pkg;

    typedef enum logic [2:0] {
        CMD_PUT_CHAR   = 3'd0,
        CMD_CLEAR      = 3'd1,
        CMD_MOVE_REL   = 3'd2,
        CMD_MOVE_ABS   = 3'd3,
        CMD_SET_COLOR  = 3'd4
    } cmd_t;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] FINAL_LO    = 8'h40;
    localparam logic [7:0] FINAL_HI    = 8'h7E;
    localparam logic [7:0] CH_UP       = 8'h41;  // A
    localparam logic [7:0] CH_DOWN     = 8'h42;  // B
    localparam logic [7:0] CH_RIGHT    = 8'h43;  // C
    localparam logic [7:0] CH_LEFT     = 8'h44;  // D
    localparam logic [7:0] CH_NEXTLN   = 8'h45;  // E
    localparam logic [7:0] CH_PREVLN   = 8'h46;  // F
    localparam logic [7:0] CH_HOME     = 8'h48;  // H
    localparam logic [7:0] CH_ERASE    = 8'h4A;  // J
    localparam logic [7:0] CH_SGR      = 8'h6D;  // m

    localparam logic [4:0] COLOR_KEEP  = 5'h1F;  // -1
    localparam logic [4:0] COLOR_WHITE = 5'd15;
    localparam logic [4:0] COLOR_BLACK = 5'd0;

    // SGR codes above this value are never meaningful.
    localparam logic [6:0] SGR_NONE    = 7'd127;

    localparam logic [6:0] SGR_RESET   = 7'd0;
    localparam logic [6:0] SGR_FG_DEF  = 7'd39;
    localparam logic [6:0] SGR_BG_DEF  = 7'd49;
    localparam logic [6:0] SGR_FG_LO   = 7'd30;
    localparam logic [6:0] SGR_FG_HI   = 7'd37;
    localparam logic [6:0] SGR_BG_LO   = 7'd40;
    localparam logic [6:0] SGR_BG_HI   = 7'd47;
    localparam logic [6:0] SGR_FGB_LO  = 7'd90;
    localparam logic [6:0] SGR_FGB_HI  = 7'd97;
    localparam logic [6:0] SGR_BGB_LO  = 7'd100;
    localparam logic [6:0] SGR_BGB_HI  = 7'd107;

    // ANSI color index to VGA palette index.
    localparam logic [2:0] PALETTE [8] = '{3'd0, 3'd4, 3'd2, 3'd6,
                                           3'd1, 3'd5, 3'd3, 3'd7};

    typedef struct packed {
        logic [4:0] fg;
        logic [4:0] bg;
    } colors_t;

    function automatic colors_t sgr_apply(input logic [6:0] code, input colors_t cur);
        colors_t    res;
        logic [6:0] idx;
        res = cur;
        idx = 7'd0;
        if (code == SGR_RESET) begin
            res.fg = COLOR_WHITE;
            res.bg = COLOR_BLACK;
        end else if (code == SGR_FG_DEF) begin
            res.fg = COLOR_WHITE;
        end else if (code == SGR_BG_DEF) begin
            res.bg = COLOR_BLACK;
        end else if (code inside {[SGR_FG_LO:SGR_FG_HI]}) begin
            idx    = code - SGR_FG_LO;
            res.fg = {2'b00, PALETTE[idx[2:0]]};
        end else if (code inside {[SGR_FGB_LO:SGR_FGB_HI]}) begin
            idx    = code - SGR_FGB_LO;
            res.fg = {2'b01, PALETTE[idx[2:0]]};
        end else if (code inside {[SGR_BG_LO:SGR_BG_HI]}) begin
            idx    = code - SGR_BG_LO;
            res.bg = {2'b00, PALETTE[idx[2:0]]};
        end else if (code inside {[SGR_BGB_LO:SGR_BGB_HI]}) begin
            idx    = code - SGR_BGB_LO;
            res.bg = {2'b01, PALETTE[idx[2:0]]};
        end
        return res;
    endfunction

endpackage

@@ design/ansi_csi_console_parser_unit.sv @@
// ----------------------------------------------------------------------------
// ANSI CSI console parser
// Turns a byte stream into console commands: printed characters, screen
// clear, cursor moves and color changes from ESC [ ... control sequences.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  tdata (low bit up)                        tuser     tlast
//  -------  ---  ----------------------------------------  --------  ------------
//  s_       in   byte_in[7:0]                              -         last_in_call
//  m_       out  char_out[7:0] move_x[16:0] move_y[16:0]   command   -
//                fg_color[4:0] bg_color[4:0] (52 bits, 4 pad)
//
// One byte is accepted per cycle while s_tready is high. A byte waits in the
// input register, then the parser state and the result register are updated
// from it once the result register is free; the result is then on m_.
// A stall on m_ holds the result register and the input register; s_tready
// drops only when both are full and m_tready is low. Reset (aresetn low,
// synchronous) empties both and returns the parser to outside any sequence.
module ansi_csi_console_parser_unit #(
    parameter int PARAM_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_in[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // char_out, move_x, move_y, fg_color, bg_color
    output logic [2:0]  m_tuser    // command
);

    localparam int ACC_W = PARAM_BITS + 5;
    localparam int EXT_W = (PARAM_BITS > 17) ? PARAM_BITS : 17;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Parser state
    logic                  saw_escape_reg, saw_escape_next;
    logic                  in_csi_reg, in_csi_next;
    logic [PARAM_BITS-1:0] param_cur_reg, param_cur_next;
    logic [PARAM_BITS-1:0] param_prev_reg, param_prev_next;
    logic                  prev_valid_reg, prev_valid_next;

    // Result register
    logic                 m_valid_reg;
    acsi_pkg::cmd_t       out_cmd_reg;
    logic [7:0]           out_char_reg;
    logic signed [16:0]   out_x_reg;
    logic signed [16:0]   out_y_reg;
    acsi_pkg::colors_t    out_col_reg;

    logic out_free;
    logic advance;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Parameter views
    logic [PARAM_BITS-1:0] p1;
    logic [PARAM_BITS-1:0] n_val;
    logic [EXT_W-1:0]      n_ext;
    logic [16:0]           n17;
    logic [PARAM_BITS-1:0] col_val;
    logic [EXT_W-1:0]      col_ext;
    logic [6:0]            code1;
    logic [6:0]            code2;
    acsi_pkg::colors_t     sgr_mid;
    acsi_pkg::colors_t     sgr_res;

    assign p1      = prev_valid_reg ? param_prev_reg : param_cur_reg;
    assign n_val   = (p1 == '0) ? PARAM_BITS'(1) : p1;
    assign n_ext   = EXT_W'(n_val);
    assign n17     = n_ext[16:0];
    // Column is zero when the second parameter is absent, zero or one.
    assign col_val = (prev_valid_reg && param_cur_reg != '0) ?
                     param_cur_reg - PARAM_BITS'(1) : '0;
    assign col_ext = EXT_W'(col_val);

    assign code1 = (|p1[PARAM_BITS-1:7]) ? acsi_pkg::SGR_NONE : p1[6:0];
    assign code2 = (!prev_valid_reg || (|param_cur_reg[PARAM_BITS-1:7])) ?
                   acsi_pkg::SGR_NONE : param_cur_reg[6:0];
    assign sgr_mid = acsi_pkg::sgr_apply(code1,
                         acsi_pkg::colors_t'{fg: acsi_pkg::COLOR_KEEP,
                                             bg: acsi_pkg::COLOR_KEEP});
    assign sgr_res = acsi_pkg::sgr_apply(code2, sgr_mid);

    // Parameter accumulation: 10 * current + (byte - '0'), clamped.
    logic signed [ACC_W-1:0] acc;
    logic [PARAM_BITS-1:0]   acc_sat;

    assign acc = (ACC_W'(param_cur_reg) << 3) + (ACC_W'(param_cur_reg) << 1)
               + ACC_W'(in_byte_reg) - ACC_W'(acsi_pkg::CH_ZERO);

    always_comb begin
        if (acc[ACC_W-1]) begin
            acc_sat = '0;
        end else if (|acc[ACC_W-2:PARAM_BITS]) begin
            acc_sat = '1;
        end else begin
            acc_sat = acc[PARAM_BITS-1:0];
        end
    end

    // Step logic
    logic                has_result;
    acsi_pkg::cmd_t      res_cmd;
    logic [7:0]          res_char;
    logic signed [16:0]  res_x;
    logic signed [16:0]  res_y;
    acsi_pkg::colors_t   res_col;

    always_comb begin
        saw_escape_next = saw_escape_reg;
        in_csi_next     = in_csi_reg;
        param_cur_next  = param_cur_reg;
        param_prev_next = param_prev_reg;
        prev_valid_next = prev_valid_reg;
        has_result      = 1'b0;
        res_cmd         = acsi_pkg::CMD_PUT_CHAR;
        res_char        = 8'd0;
        res_x           = '0;
        res_y           = '0;
        res_col         = '{fg: acsi_pkg::COLOR_KEEP, bg: acsi_pkg::COLOR_KEEP};

        if (in_csi_reg) begin
            if (in_byte_reg inside {[acsi_pkg::FINAL_LO:acsi_pkg::FINAL_HI]}) begin
                in_csi_next = 1'b0;
                case (in_byte_reg)
                    acsi_pkg::CH_ERASE: begin
                        has_result = (p1 == PARAM_BITS'(2));
                        res_cmd    = acsi_pkg::CMD_CLEAR;
                    end
                    acsi_pkg::CH_UP, acsi_pkg::CH_PREVLN: begin
                        has_result = 1'b1;
                        res_cmd    = acsi_pkg::CMD_MOVE_REL;
                        res_y      = -n17;
                    end
                    acsi_pkg::CH_DOWN, acsi_pkg::CH_NEXTLN: begin
                        has_result = 1'b1;
                        res_cmd    = acsi_pkg::CMD_MOVE_REL;
                        res_y      = n17;
                    end
                    acsi_pkg::CH_RIGHT: begin
                        has_result = 1'b1;
                        res_cmd    = acsi_pkg::CMD_MOVE_REL;
                        res_x      = n17;
                    end
                    acsi_pkg::CH_LEFT: begin
                        has_result = 1'b1;
                        res_cmd    = acsi_pkg::CMD_MOVE_REL;
                        res_x      = -n17;
                    end
                    acsi_pkg::CH_HOME: begin
                        has_result = 1'b1;
                        res_cmd    = acsi_pkg::CMD_MOVE_ABS;
                        res_x      = col_ext[16:0];
                        res_y      = n17 - 17'd1;
                    end
                    acsi_pkg::CH_SGR: begin
                        has_result = 1'b1;
                        res_cmd    = acsi_pkg::CMD_SET_COLOR;
                        res_col    = sgr_res;
                    end
                    default: begin
                        has_result = 1'b0;
                    end
                endcase
            end else if (in_byte_reg == acsi_pkg::CH_SEMI) begin
                param_prev_next = param_cur_reg;
                prev_valid_next = 1'b1;
                param_cur_next  = '0;
            end else begin
                param_cur_next = acc_sat;
            end
        end else if (saw_escape_reg && in_byte_reg == acsi_pkg::CH_LBRACKET) begin
            in_csi_next     = 1'b1;
            saw_escape_next = 1'b0;
            param_cur_next  = '0;
            prev_valid_next = 1'b0;
        end else if (in_byte_reg == acsi_pkg::CH_ESC) begin
            saw_escape_next = 1'b1;
        end else begin
            has_result      = 1'b1;
            res_char        = in_byte_reg;
            saw_escape_next = 1'b0;
        end

        // Sequences never span writes.
        if (in_last_reg) begin
            saw_escape_next = 1'b0;
            in_csi_next     = 1'b0;
            param_cur_next  = '0;
            prev_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            saw_escape_reg <= 1'b0;
            in_csi_reg     <= 1'b0;
            param_cur_reg  <= '0;
            prev_valid_reg <= 1'b0;
        end else if (advance) begin
            saw_escape_reg <= saw_escape_next;
            in_csi_reg     <= in_csi_next;
            param_cur_reg  <= param_cur_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            param_prev_reg <= param_prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= has_result;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_result) begin
            out_cmd_reg  <= res_cmd;
            out_char_reg <= res_char;
            out_x_reg    <= res_x;
            out_y_reg    <= res_y;
            out_col_reg  <= res_col;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_cmd_reg;
    assign m_tdata  = {4'd0, out_col_reg.bg, out_col_reg.fg,
                       out_y_reg, out_x_reg, out_char_reg};

endmodule

@@ design/acsi_checker.sv @@
// ----------------------------------------------------------------------------
// ANSI CSI console parser port checker
// Watches the ports of the parser for result stability and well-formed items.
// ----------------------------------------------------------------------------
module acsi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_cmd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= acsi_pkg::CMD_SET_COLOR)
        else $error("command code out of range");

    // Only printed characters carry a byte, and ESC is never printed.
    a_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == acsi_pkg::CMD_PUT_CHAR) ?
                     (m_tdata[7:0] != acsi_pkg::CH_ESC) : (m_tdata[7:0] == 8'd0))
        else $error("character field inconsistent with command");

    a_colors: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != acsi_pkg::CMD_SET_COLOR |->
            m_tdata[46:42] == acsi_pkg::COLOR_KEEP && m_tdata[51:47] == acsi_pkg::COLOR_KEEP)
        else $error("color fields set on a non-color command");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind ansi_csi_console_parser_unit acsi_checker u_acsi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
